// ===== hdl/ripf_pkg.sv =====
// Shared types, constants and helper functions for the regex infix-to-postfix converter.
`timescale 1ns / 1ps

package ripf_pkg;

    localparam int SYM_W  = 7;
    localparam int STAT_W = 2;
    localparam int OPC_W  = 2;

    // ASCII codes of the operator characters
    localparam logic [SYM_W-1:0] CH_OPEN  = 7'h28;
    localparam logic [SYM_W-1:0] CH_CLOSE = 7'h29;
    localparam logic [SYM_W-1:0] CH_STAR  = 7'h2A;
    localparam logic [SYM_W-1:0] CH_CAT   = 7'h2B;
    localparam logic [SYM_W-1:0] CH_ALT   = 7'h7C;

    // Operator codes as kept on the stack
    typedef enum logic [OPC_W-1:0] {
        OPC_OPEN = 2'd0,
        OPC_STAR = 2'd1,
        OPC_ALT  = 2'd2,
        OPC_CAT  = 2'd3
    } opc_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK              = 2'd0,
        ST_UNMATCHED_CLOSE = 2'd1,
        ST_OVERFLOW        = 2'd2,
        ST_UNMATCHED_OPEN  = 2'd3
    } status_t;

    // Source of an emitted result
    typedef enum logic [1:0] {
        EM_TOP    = 2'd0,
        EM_SYMBOL = 2'd1,
        EM_STATUS = 2'd2
    } emit_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      pop;
        logic      push;
        logic      emit;
        emit_sel_t emit_sel;
        status_t   emit_status;
        logic      set_open;
        logic      finish;
    } ripf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_operand;
        logic in_close;
        logic in_concat;
        logic item_operand;
        logic stack_empty;
        logic stack_full;
        logic top_open;
        logic top_pops;
        logic open_left;
        logic fin;
        logic emit_ok;
        logic done_ok;
    } ripf_stat_t;

    function automatic logic is_operand(input logic [SYM_W-1:0] sym);
        is_operand = (sym != CH_OPEN) && (sym != CH_CLOSE) && (sym != CH_STAR) &&
                     (sym != CH_CAT) && (sym != CH_ALT);
    endfunction

    // Operator character to stack code; any character other than (, * and | maps to the concatenation code
    function automatic opc_t sym_to_opc(input logic [SYM_W-1:0] sym);
        opc_t code;
        code = OPC_CAT;
        if (sym == CH_OPEN)
            code = OPC_OPEN;
        else if (sym == CH_STAR)
            code = OPC_STAR;
        else if (sym == CH_ALT)
            code = OPC_ALT;
        sym_to_opc = code;
    endfunction

    function automatic logic [SYM_W-1:0] op_ascii(input opc_t code);
        logic [SYM_W-1:0] ch;
        unique case (code)
            OPC_OPEN: ch = CH_OPEN;
            OPC_STAR: ch = CH_STAR;
            OPC_ALT:  ch = CH_ALT;
            OPC_CAT:  ch = CH_CAT;
            default:  ch = CH_CAT;
        endcase
        op_ascii = ch;
    endfunction

    // Binding strength: ( > * > | > +
    function automatic logic [2:0] op_rank(input opc_t code);
        logic [2:0] r;
        unique case (code)
            OPC_OPEN: r = 3'd4;
            OPC_STAR: r = 3'd3;
            OPC_ALT:  r = 3'd2;
            OPC_CAT:  r = 3'd1;
            default:  r = 3'd1;
        endcase
        op_rank = r;
    endfunction

endpackage

// ===== hdl/ripf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ripf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ripf_dpath.sv =====
// Datapath: operator stack, item registers, result holding stage and output register.
`timescale 1ns / 1ps

module ripf_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ripf_pkg::SYM_W-1:0] symbol,
    input  logic                      final_char,
    input  ripf_pkg::ripf_cmd_t       cmd,
    output ripf_pkg::ripf_stat_t      stat,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic [ripf_pkg::SYM_W-1:0] out_symbol,
    output logic                      has_symbol,
    output logic                      run_end,
    output logic                      expr_end,
    output logic [ripf_pkg::STAT_W-1:0] status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Stack and item state
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          prev_reg, prev_next;
    logic                          open_left_reg, open_left_next;
    logic                          fin_reg, fin_next;
    logic                          item_operand_reg, item_operand_next;
    ripf_pkg::opc_t                cur_code_reg, cur_code_next;
    logic [ripf_pkg::SYM_W-1:0]    item_sym_reg, item_sym_next;

    // Held result (waits until it is known whether it ends the run)
    logic                          pend_valid_reg, pend_valid_next;
    logic [ripf_pkg::SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                          pend_has_reg, pend_has_next;
    ripf_pkg::status_t             pend_status_reg, pend_status_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [ripf_pkg::SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic                          out_has_reg, out_has_next;
    logic                          out_run_reg, out_run_next;
    logic                          out_expr_reg, out_expr_next;
    ripf_pkg::status_t             out_status_reg, out_status_next;

    logic [CNT_W-1:0]              count_dec;
    logic [ripf_pkg::OPC_W-1:0]    rd_data;
    ripf_pkg::opc_t                top_code;
    logic                          out_free;
    logic                          in_operand;
    logic [ripf_pkg::SYM_W-1:0]    new_sym;
    logic                          new_has;
    ripf_pkg::status_t             new_status;

    assign count_dec = count_reg - CNT_W'(1);
    assign top_code  = ripf_pkg::opc_t'(rd_data);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_operand = ripf_pkg::is_operand(symbol);

    // Operator stack; read address always tracks the top entry
    ripf_ram #(
        .WIDTH (ripf_pkg::OPC_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cur_code_reg),
        .rd_addr (count_dec[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Status toward the controller
    always_comb
    begin
        stat.in_operand   = in_operand;
        stat.in_close     = (symbol == ripf_pkg::CH_CLOSE);
        stat.in_concat    = in_operand && prev_reg;
        stat.item_operand = item_operand_reg;
        stat.stack_empty  = (count_reg == '0);
        stat.stack_full   = (count_reg == CNT_W'(STACK_DEPTH));
        stat.top_open     = (top_code == ripf_pkg::OPC_OPEN);
        stat.top_pops     = (top_code != ripf_pkg::OPC_OPEN) &&
                            !(ripf_pkg::op_rank(cur_code_reg) > ripf_pkg::op_rank(top_code));
        stat.open_left    = open_left_reg;
        stat.fin          = fin_reg;
        stat.emit_ok      = !pend_valid_reg || out_free;
        stat.done_ok      = out_free || (!pend_valid_reg && !fin_reg);
    end

    // Value of a newly emitted result
    always_comb
    begin
        new_sym    = '0;
        new_has    = 1'b0;
        new_status = ripf_pkg::ST_OK;
        unique case (cmd.emit_sel)
            ripf_pkg::EM_TOP:
            begin
                new_sym = ripf_pkg::op_ascii(top_code);
                new_has = 1'b1;
            end
            ripf_pkg::EM_SYMBOL:
            begin
                new_sym = item_sym_reg;
                new_has = 1'b1;
            end
            ripf_pkg::EM_STATUS:
            begin
                new_status = cmd.emit_status;
            end
            default:
            begin
                new_sym = '0;
            end
        endcase
    end

    // Item and stack bookkeeping
    always_comb
    begin
        count_next        = count_reg;
        prev_next         = prev_reg;
        open_left_next    = open_left_reg;
        fin_next          = fin_reg;
        item_operand_next = item_operand_reg;
        cur_code_next     = cur_code_reg;
        item_sym_next     = item_sym_reg;
        if (cmd.load)
        begin
            item_sym_next     = symbol;
            fin_next          = final_char;
            item_operand_next = in_operand;
            cur_code_next     = in_operand ? ripf_pkg::OPC_CAT : ripf_pkg::sym_to_opc(symbol);
            prev_next         = in_operand;
            open_left_next    = 1'b0;
        end
        if (cmd.pop)
            count_next = count_dec;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        if (cmd.set_open)
            open_left_next = 1'b1;
        if (cmd.finish && fin_reg)
        begin
            count_next = '0;
            prev_next  = 1'b0;
        end
    end

    // Held result and output register
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_sym_next    = pend_sym_reg;
        pend_has_next    = pend_has_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_sym_next     = out_sym_reg;
        out_has_next     = out_has_reg;
        out_run_next     = out_run_reg;
        out_expr_next    = out_expr_reg;
        out_status_next  = out_status_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // a new result pushes the held one out as a mid-run result
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_sym_next    = pend_sym_reg;
                out_has_next    = pend_has_reg;
                out_status_next = pend_status_reg;
                out_run_next    = 1'b0;
                out_expr_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_sym_next    = new_sym;
            pend_has_next    = new_has;
            pend_status_next = new_status;
        end

        // end of item: held result closes the run, or an empty final gets a status result
        if (cmd.finish)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_sym_next    = pend_sym_reg;
                out_has_next    = pend_has_reg;
                out_status_next = pend_status_reg;
                out_run_next    = 1'b1;
                out_expr_next   = fin_reg;
            end
            else if (fin_reg)
            begin
                out_valid_next  = 1'b1;
                out_sym_next    = '0;
                out_has_next    = 1'b0;
                out_status_next = ripf_pkg::ST_OK;
                out_run_next    = 1'b1;
                out_expr_next   = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_reg       <= 1'b0;
            open_left_reg  <= 1'b0;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            prev_reg       <= prev_next;
            open_left_reg  <= open_left_next;
            fin_reg        <= fin_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_operand_reg <= item_operand_next;
        cur_code_reg     <= cur_code_next;
        item_sym_reg     <= item_sym_next;
        pend_sym_reg     <= pend_sym_next;
        pend_has_reg     <= pend_has_next;
        pend_status_reg  <= pend_status_next;
        out_sym_reg      <= out_sym_next;
        out_has_reg      <= out_has_next;
        out_run_reg      <= out_run_next;
        out_expr_reg     <= out_expr_next;
        out_status_reg   <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign has_symbol = out_has_reg;
    assign run_end    = out_run_reg;
    assign expr_end   = out_expr_reg;
    assign status     = out_status_reg;

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from empty stack");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CNT_W'(STACK_DEPTH)))
        else $error("push onto full stack");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!pend_valid_reg || out_free))
        else $error("result emitted with no room");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && fin_reg) |=> ((count_reg == '0) && !prev_reg))
        else $error("final item left state behind");

    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!pend_valid_reg && !cmd.emit))
        else $error("new item loaded with a held result");
`endif

endmodule

// ===== hdl/ripf_ctrl.sv =====
// Controller: sequences operator handling, close-paren unwinding and final flush.
`timescale 1ns / 1ps

module ripf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ripf_pkg::ripf_stat_t stat,
    output ripf_pkg::ripf_cmd_t  cmd,
    output logic                 busy
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_OP_READ   = 12'b0000_0000_0010,
        S_OP_CHECK  = 12'b0000_0000_0100,
        S_OP_PUSH   = 12'b0000_0000_1000,
        S_SYM       = 12'b0000_0001_0000,
        S_CL_READ   = 12'b0000_0010_0000,
        S_CL_CHECK  = 12'b0000_0100_0000,
        S_CL_ERR    = 12'b0000_1000_0000,
        S_FL_READ   = 12'b0001_0000_0000,
        S_FL_CHECK  = 12'b0010_0000_0000,
        S_FL_STATUS = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t after_item;

    // After the character itself: flush on the final item, else wrap up
    assign after_item = stat.fin ? S_FL_READ : S_DONE;
    assign busy       = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_close)
                        state_next = S_CL_READ;
                    else if (stat.in_operand && !stat.in_concat)
                        state_next = S_SYM;
                    else
                        state_next = S_OP_READ;
                end
            end
            S_OP_READ:
            begin
                state_next = stat.stack_empty ? S_OP_PUSH : S_OP_CHECK;
            end
            S_OP_CHECK:
            begin
                if (!stat.top_pops)
                    state_next = S_OP_PUSH;
                else if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = ripf_pkg::EM_TOP;
                    cmd.pop      = 1'b1;
                    state_next   = S_OP_READ;
                end
            end
            S_OP_PUSH:
            begin
                if (!stat.stack_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = stat.item_operand ? S_SYM : after_item;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = ripf_pkg::EM_STATUS;
                    cmd.emit_status = ripf_pkg::ST_OVERFLOW;
                    state_next      = stat.item_operand ? S_SYM : after_item;
                end
            end
            S_SYM:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = ripf_pkg::EM_SYMBOL;
                    state_next   = after_item;
                end
            end
            S_CL_READ:
            begin
                state_next = stat.stack_empty ? S_CL_ERR : S_CL_CHECK;
            end
            S_CL_CHECK:
            begin
                if (stat.top_open)
                begin
                    cmd.pop    = 1'b1;
                    state_next = after_item;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = ripf_pkg::EM_TOP;
                    cmd.pop      = 1'b1;
                    state_next   = S_CL_READ;
                end
            end
            S_CL_ERR:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = ripf_pkg::EM_STATUS;
                    cmd.emit_status = ripf_pkg::ST_UNMATCHED_CLOSE;
                    state_next      = after_item;
                end
            end
            S_FL_READ:
            begin
                if (!stat.stack_empty)
                    state_next = S_FL_CHECK;
                else
                    state_next = stat.open_left ? S_FL_STATUS : S_DONE;
            end
            S_FL_CHECK:
            begin
                if (stat.top_open)
                begin
                    cmd.pop      = 1'b1;
                    cmd.set_open = 1'b1;
                    state_next   = S_FL_READ;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = ripf_pkg::EM_TOP;
                    cmd.pop      = 1'b1;
                    state_next   = S_FL_READ;
                end
            end
            S_FL_STATUS:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = ripf_pkg::EM_STATUS;
                    cmd.emit_status = ripf_pkg::ST_UNMATCHED_OPEN;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.done_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("item loaded while busy");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in one cycle");
`endif

endmodule

// ===== hdl/regex_infix_to_postfix_top.sv =====
// Top level of the regex infix-to-postfix converter.
`timescale 1ns / 1ps

// Regular expression infix-to-postfix converter.
// Input channel (in_valid / in_stall): one ASCII character per transfer in
// symbol, with final_char set on the last character of the expression.
// Output channel (out_valid / out_stall): postfix characters in out_symbol
// (has_symbol = 1) or status-only results (has_symbol = 0, code in status).
// run_end marks the last result caused by an input character, expr_end the
// last result of the expression. A character that produces nothing gives no
// transfer, except a final one, which always gives at least one result.
// With no output stall, a plain operand runs load, symbol and done steps; an
// operator or a ')' runs load, stack read, push or pop, and done (a ')' pops
// its '(' there), plus a check and a read per operator popped, a check when
// an operator stops on an entry it leaves in place, and a symbol step for an
// implied concatenation. A final character adds a flush read, a check and a
// read per entry flushed, and a status step for a leftover '('. Each result
// waits in a holding stage until the next one is made or the character ends.
// in_stall is high while a character is being worked on. A stalled output
// holds its result and the sequencer waits on the next result. Reset empties
// the operator stack and drops any result in flight; stack RAM contents are
// not cleared and are never read before being written.

module regex_infix_to_postfix_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ripf_pkg::SYM_W-1:0]  symbol,
    input  logic                        final_char,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ripf_pkg::SYM_W-1:0]  out_symbol,
    output logic                        has_symbol,
    output logic                        run_end,
    output logic                        expr_end,
    output logic [ripf_pkg::STAT_W-1:0] status
);

    ripf_pkg::ripf_cmd_t  cmd;
    ripf_pkg::ripf_stat_t stat;
    logic                 busy;

    assign in_stall = busy;

    // Sequencer
    ripf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Stack, item registers and output stage
    ripf_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (symbol),
        .final_char (final_char),
        .cmd        (cmd),
        .stat       (stat),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_symbol (out_symbol),
        .has_symbol (has_symbol),
        .run_end    (run_end),
        .expr_end   (expr_end),
        .status     (status)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the regex infix-to-postfix converter.
`timescale 1ns / 1ps

module testbench;

    localparam int SYM_W        = ripf_pkg::SYM_W;
    localparam int STAT_W       = ripf_pkg::STAT_W;
    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 210;
    localparam int QUIET_TAIL   = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_PER_ITEM = 18;

    // One postfix result as seen on the output channel
    typedef struct {
        logic [SYM_W-1:0]  sym;
        bit                has;
        bit                run_end;
        bit                expr_end;
        ripf_pkg::status_t st;
    } postfix_res_t;

    // Shunting-yard predictor plus the queue of postfix results still owed
    class postfix_scoreboard #(int DEPTH = 16);
        ripf_pkg::opc_t held_ops[DEPTH];
        int             depth_used;
        bit             after_operand;
        postfix_res_t   batch[$];
        postfix_res_t   owed_q[$];
        int             errors;
        int             checked;
        int             exprs;
        int             status_hits[4];

        function new();
            depth_used    = 0;
            after_operand = 1'b0;
            errors        = 0;
            checked       = 0;
            exprs         = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function logic [SYM_W-1:0] op_char(ripf_pkg::opc_t c);
            case (c)
                ripf_pkg::OPC_OPEN: return ripf_pkg::CH_OPEN;
                ripf_pkg::OPC_STAR: return ripf_pkg::CH_STAR;
                ripf_pkg::OPC_ALT:  return ripf_pkg::CH_ALT;
                default:            return ripf_pkg::CH_CAT;
            endcase
        endfunction

        // ( binds tightest, then *, |, and concatenation last
        function int binding(ripf_pkg::opc_t c);
            case (c)
                ripf_pkg::OPC_OPEN: return 4;
                ripf_pkg::OPC_STAR: return 3;
                ripf_pkg::OPC_ALT:  return 2;
                default:            return 1;
            endcase
        endfunction

        function void add_result(logic [SYM_W-1:0] s, bit has, ripf_pkg::status_t st);
            postfix_res_t r;
            r.sym      = has ? s : '0;
            r.has      = has;
            r.run_end  = 1'b0;
            r.expr_end = 1'b0;
            r.st       = st;
            if (batch.size() < MAX_PER_ITEM)
                batch.push_back(r);
        endfunction

        // Pop everything that binds at least as tight, then push (or overflow)
        function void apply_operator(ripf_pkg::opc_t code);
            while (depth_used > 0 && held_ops[depth_used-1] != ripf_pkg::OPC_OPEN &&
                   binding(code) <= binding(held_ops[depth_used-1]))
            begin
                depth_used--;
                add_result(op_char(held_ops[depth_used]), 1'b1, ripf_pkg::ST_OK);
            end
            if (depth_used >= DEPTH)
                add_result('0, 1'b0, ripf_pkg::ST_OVERFLOW);
            else
            begin
                held_ops[depth_used] = code;
                depth_used++;
            end
        endfunction

        // Work out the results of one accepted input transfer
        function void note_input(logic [SYM_W-1:0] sym, bit fin);
            bit open_left;
            batch.delete();
            case (sym)
                ripf_pkg::CH_OPEN:
                begin
                    after_operand = 1'b0;
                    apply_operator(ripf_pkg::OPC_OPEN);
                end
                ripf_pkg::CH_STAR:
                begin
                    after_operand = 1'b0;
                    apply_operator(ripf_pkg::OPC_STAR);
                end
                ripf_pkg::CH_ALT:
                begin
                    after_operand = 1'b0;
                    apply_operator(ripf_pkg::OPC_ALT);
                end
                ripf_pkg::CH_CAT:
                begin
                    after_operand = 1'b0;
                    apply_operator(ripf_pkg::OPC_CAT);
                end
                ripf_pkg::CH_CLOSE:
                begin
                    after_operand = 1'b0;
                    while (depth_used > 0 && held_ops[depth_used-1] != ripf_pkg::OPC_OPEN)
                    begin
                        depth_used--;
                        add_result(op_char(held_ops[depth_used]), 1'b1, ripf_pkg::ST_OK);
                    end
                    if (depth_used > 0)
                        depth_used--;
                    else
                        add_result('0, 1'b0, ripf_pkg::ST_UNMATCHED_CLOSE);
                end
                default:
                begin
                    // implied concatenation between adjacent operands
                    if (after_operand)
                        apply_operator(ripf_pkg::OPC_CAT);
                    add_result(sym, 1'b1, ripf_pkg::ST_OK);
                    after_operand = 1'b1;
                end
            endcase

            // Final flush: leftover opens are dropped and flagged once
            if (fin)
            begin
                open_left = 1'b0;
                while (depth_used > 0)
                begin
                    depth_used--;
                    if (held_ops[depth_used] == ripf_pkg::OPC_OPEN)
                        open_left = 1'b1;
                    else
                        add_result(op_char(held_ops[depth_used]), 1'b1, ripf_pkg::ST_OK);
                end
                if (open_left)
                    add_result('0, 1'b0, ripf_pkg::ST_UNMATCHED_OPEN);
                if (batch.size() == 0)
                    add_result('0, 1'b0, ripf_pkg::ST_OK);
                batch[batch.size()-1].expr_end = 1'b1;
                after_operand = 1'b0;
                exprs++;
            end

            if (batch.size() > 0)
                batch[batch.size()-1].run_end = 1'b1;
            foreach (batch[i])
                owed_q.push_back(batch[i]);
        endfunction

        function bit field_ok(string name, logic [SYM_W-1:0] want, logic [SYM_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                return 0;
            end
            return 1;
        endfunction

        // Compare one output transfer with the oldest owed result
        function void check_result(logic [SYM_W-1:0] sym, logic has, logic re, logic ee,
                                   logic [STAT_W-1:0] st);
            postfix_res_t want;
            bit           ok;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got symbol %0h has %0b status %0d",
                         $time, sym, has, st);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            ok = 1'b1;
            ok &= field_ok("out_symbol", want.sym, sym);
            ok &= field_ok("has_symbol", SYM_W'(want.has), SYM_W'(has));
            ok &= field_ok("run_end", SYM_W'(want.run_end), SYM_W'(re));
            ok &= field_ok("expr_end", SYM_W'(want.expr_end), SYM_W'(ee));
            ok &= field_ok("status", SYM_W'(want.st), SYM_W'(st));
            status_hits[want.st]++;
            if (!ok)
                errors++;
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SYM_W-1:0]    symbol;
    logic                final_char;
    logic                out_valid;
    logic                out_stall;
    logic [SYM_W-1:0]    out_symbol;
    logic                has_symbol;
    logic                run_end;
    logic                expr_end;
    logic [STAT_W-1:0]   status;

    postfix_scoreboard #(STACK_DEPTH) sb;
    bit                  idle_on;
    int                  items_sent;
    int                  cycles;
    logic [SYM_W-1:0]    expr_q[$];

    regex_infix_to_postfix_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_symbol (out_symbol),
        .has_symbol (has_symbol),
        .run_end    (run_end),
        .expr_end   (expr_end),
        .status     (status)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results still owed", $time, sb.owed());
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Output side: check each transfer, stall in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_symbol, has_symbol, run_end, expr_end, status);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Input side: one character per transfer, with random gaps before it
    task automatic send_item(logic [SYM_W-1:0] sym, bit fin);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        symbol     <= sym;
        final_char <= fin;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(sym, fin);
        items_sent++;
    endtask

    task automatic send_expr();
        foreach (expr_q[i])
            send_item(expr_q[i], i == expr_q.size() - 1);
    endtask

    function automatic logic [SYM_W-1:0] pick_operand();
        logic [SYM_W-1:0] s;
        do
            s = SYM_W'($urandom_range(0, 127));
        while (s == ripf_pkg::CH_OPEN || s == ripf_pkg::CH_CLOSE || s == ripf_pkg::CH_STAR ||
               s == ripf_pkg::CH_CAT || s == ripf_pkg::CH_ALT);
        return s;
    endfunction

    // Well-formed expression with random content; deep ones start with a run of opens
    task automatic build_wellformed(bit deep);
        int opens;
        int steps;
        int nest_cap;
        int r;
        bit need_opd;
        expr_q.delete();
        opens    = 0;
        need_opd = 1'b1;
        nest_cap = deep ? 18 : 4;
        steps    = $urandom_range(1, 14);
        if (deep)
            repeat ($urandom_range(12, 18))
            begin
                expr_q.push_back(ripf_pkg::CH_OPEN);
                opens++;
            end
        while (steps > 0 || need_opd || opens > 0)
        begin
            if (steps <= 0)
            begin
                // close out what is open
                if (need_opd)
                begin
                    expr_q.push_back(pick_operand());
                    need_opd = 1'b0;
                end
                else
                begin
                    expr_q.push_back(ripf_pkg::CH_CLOSE);
                    opens--;
                end
            end
            else if (need_opd)
            begin
                if (opens < nest_cap && $urandom_range(0, 3) == 0)
                begin
                    expr_q.push_back(ripf_pkg::CH_OPEN);
                    opens++;
                end
                else
                begin
                    expr_q.push_back(pick_operand());
                    need_opd = 1'b0;
                end
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r <= 1)
                    expr_q.push_back(ripf_pkg::CH_STAR);
                else if (r <= 3)
                begin
                    expr_q.push_back(ripf_pkg::CH_ALT);
                    need_opd = 1'b1;
                end
                else if (r == 4)
                begin
                    expr_q.push_back(ripf_pkg::CH_CAT);
                    need_opd = 1'b1;
                end
                else if (r <= 6 && opens > 0)
                begin
                    expr_q.push_back(ripf_pkg::CH_CLOSE);
                    opens--;
                end
                else
                    expr_q.push_back(pick_operand());
            end
            steps--;
        end
    endtask

    // Noise: any characters in any order, operators favored
    task automatic build_noise();
        expr_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                0:       expr_q.push_back(ripf_pkg::CH_OPEN);
                1:       expr_q.push_back(ripf_pkg::CH_CLOSE);
                2:       expr_q.push_back(ripf_pkg::CH_STAR);
                3:       expr_q.push_back(ripf_pkg::CH_CAT);
                4:       expr_q.push_back(ripf_pkg::CH_ALT);
                default: expr_q.push_back(SYM_W'($urandom_range(0, 127)));
            endcase
        end
    endtask

    // Stimulus
    initial
    begin
        int mode;
        sb         = new();
        idle_on    = 1'b1;
        items_sent = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        symbol     <= '0;
        final_char <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme codes with implied concatenation, every operator but '(', stray close
        send_item(7'h00, 1'b0);
        send_item(7'h7F, 1'b0);
        send_item(ripf_pkg::CH_STAR, 1'b0);
        send_item(ripf_pkg::CH_ALT, 1'b0);
        send_item(7'h41, 1'b0);
        send_item(ripf_pkg::CH_CAT, 1'b0);
        send_item(7'h42, 1'b0);
        send_item(ripf_pkg::CH_CLOSE, 1'b1);
        // Final that yields nothing of its own
        send_item(ripf_pkg::CH_OPEN, 1'b0);
        send_item(ripf_pkg::CH_CLOSE, 1'b1);
        // Full stack: one more operator overflows, flush flags leftover opens
        repeat (STACK_DEPTH) send_item(ripf_pkg::CH_OPEN, 1'b0);
        send_item(ripf_pkg::CH_STAR, 1'b1);

        // Random expressions, mostly well formed
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_on = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            mode    = $urandom_range(0, 19);
            if (mode == 0)
                build_wellformed(1'b1);
            else if (mode <= 3)
                build_noise();
            else
                build_wellformed(1'b0);
            send_expr();
        end
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (sb.owed() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d expressions; %0d postfix results compared.",
                 items_sent, sb.exprs, sb.checked);
        $display("Status results: %0d unmatched close, %0d overflow, %0d unmatched open.",
                 sb.status_hits[ripf_pkg::ST_UNMATCHED_CLOSE],
                 sb.status_hits[ripf_pkg::ST_OVERFLOW],
                 sb.status_hits[ripf_pkg::ST_UNMATCHED_OPEN]);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
